// ===== sv/ctscan_pkg.sv =====
// shared types, token codes and keyword tables for the c subset token scanner
`timescale 1ns / 1ps
package ctscan_pkg;

  localparam int unsigned TokenBufferSizeDefault = 256;
  localparam int unsigned ResultSlots = 3;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_DQUOTE = 2'd1,
    MODE_SQUOTE = 2'd2,
    MODE_HALTED = 2'd3
  } scan_mode_e;

  // token kinds
  localparam logic [4:0] KIND_INT    = 5'd0;
  localparam logic [4:0] KIND_FLOAT  = 5'd2;
  localparam logic [4:0] KIND_IDENT  = 5'd4;
  localparam logic [4:0] KIND_TEXT   = 5'd5;
  localparam logic [4:0] KIND_LETTER = 5'd6;
  localparam logic [4:0] KIND_DOT    = 5'd13;
  localparam logic [4:0] KIND_END    = 5'd31;
  localparam logic [4:0] KIND_NONE   = 5'd0;

  // pending operator codes
  localparam logic [3:0] PEND_NONE = 4'd0;
  localparam logic [3:0] PEND_DOT  = 4'd8;

  // numeric flag bits
  localparam int unsigned NumOk     = 0;
  localparam int unsigned NumPoint  = 1;
  localparam int unsigned NumBefore = 2;
  localparam int unsigned NumAfter  = 3;
  localparam logic [3:0] NUM_RESET  = 4'b0001;
  localparam logic [3:0] KW_RESET   = 4'b1111;

  typedef struct packed {
    logic [7:0]  len;
    logic [31:0] start;
    logic [3:0]  kf;
    logic [3:0]  nf;
  } word_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] line;
    logic [31:0] start;
    logic [7:0]  len;
    logic        err;
    logic        last;
  } res_t;

  function automatic logic [7:0] kw_len(input logic [1:0] k);
    unique case (k)
      2'd0:    return 8'd3;
      2'd1:    return 8'd4;
      2'd2:    return 8'd5;
      default: return 8'd4;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [39:0] s;
    unique case (k)
      2'd0:    s = {8'h00, 8'h00, "t", "n", "i"};
      2'd1:    s = {8'h00, "r", "a", "h", "c"};
      2'd2:    s = {"t", "a", "o", "l", "f"};
      default: s = {8'h00, "d", "i", "o", "v"};
    endcase
    case (idx)
      3'd0:    return s[7:0];
      3'd1:    return s[15:8];
      3'd2:    return s[23:16];
      3'd3:    return s[31:24];
      3'd4:    return s[39:32];
      default: return 8'h00;
    endcase
  endfunction

  // operators that may take a second byte: codes 1 to 7, zero if none
  function automatic logic [3:0] pend_code(input logic [7:0] c);
    case (c)
      "|":     return 4'd1;
      "+":     return 4'd2;
      ">":     return 4'd3;
      "<":     return 4'd4;
      "=":     return 4'd5;
      "!":     return 4'd6;
      "&":     return 4'd7;
      default: return PEND_NONE;
    endcase
  endfunction

  function automatic logic [7:0] pend_second(input logic [3:0] p);
    case (p)
      4'd1:    return "|";
      4'd2:    return "+";
      4'd7:    return "&";
      default: return "=";
    endcase
  endfunction

  function automatic logic [4:0] pend_two(input logic [3:0] p);
    case (p)
      4'd1:    return 5'd7;
      4'd2:    return 5'd10;
      4'd3:    return 5'd14;
      4'd4:    return 5'd16;
      4'd5:    return 5'd18;
      4'd6:    return 5'd27;
      default: return 5'd29;
    endcase
  endfunction

  function automatic logic [4:0] pend_one(input logic [3:0] p);
    case (p)
      4'd1:    return 5'd8;
      4'd2:    return 5'd11;
      4'd3:    return 5'd15;
      4'd4:    return 5'd17;
      4'd5:    return 5'd19;
      4'd6:    return 5'd28;
      default: return 5'd30;
    endcase
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    case (c)
      "/":     return 5'd9;
      "-":     return 5'd12;
      ";":     return 5'd20;
      ",":     return 5'd21;
      "(":     return 5'd22;
      ")":     return 5'd23;
      "{":     return 5'd24;
      "}":     return 5'd25;
      "*":     return 5'd26;
      default: return KIND_NONE;
    endcase
  endfunction

endpackage

// ===== sv/c_subset_token_scanner.sv =====
// top level of the c subset token scanner: classification logic and result queue
//
// usage
//   s_axis carries one source byte per item in tdata; tlast marks end of input,
//   and then tdata is ignored, pending state is flushed and an end token follows
//   m_axis carries one token per item: tuser holds kind and error flag, tdata
//   holds line, start and length; tlast marks the final token caused by an input
// flow and throughput
//   an accepted byte is classified in the cycle it is accepted and its tokens
//   are registered into the result queue, which sends one token per cycle
//   while m_axis_tready_i is high; one byte per cycle while the queue has room;
//   a byte may queue two or three tokens in the four entry result queue
//   s_axis_tready_o is high while at least three queue entries are free
// reset and stalls
//   rst_ni clears scanner state, positions, line count and the queue
//   a stalled receiver holds the head token; bytes are still taken until the
//   queue cannot hold three more tokens
//   after an invalid byte the error token is sent and later bytes give nothing
`timescale 1ns / 1ps
module c_subset_token_scanner
  import ctscan_pkg::*;
#(
  parameter int unsigned TOKEN_BUFFER_SIZE = TokenBufferSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // line_number, start_position, text_length
  output logic [5:0]  m_axis_tuser_o,   // token_kind, syntax_error
  output logic        m_axis_tlast_o    // last_of_run
);

  // length cap for words and quoted text
  localparam logic [7:0] TextCap =
      (TOKEN_BUFFER_SIZE - 1 > 255) ? 8'd255 : 8'(TOKEN_BUFFER_SIZE - 1);
  localparam word_t WordReset = '{len: 8'd0, start: 32'd0, kf: KW_RESET, nf: NUM_RESET};

  // scanner state
  scan_mode_e  mode_q, mode_d;
  logic [3:0]  pend_q, pend_d;
  word_t       word_q, word_d;
  logic [7:0]  qlen_q, qlen_d;
  logic [31:0] qstart_q, qstart_d;
  logic [31:0] bpos_q, bpos_d;
  logic [31:0] lcnt_q, lcnt_d;

  // results of the current byte
  res_t        slot[ResultSlots];
  logic [1:0]  nres;

  // result queue
  res_t        queue_q[4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;

  logic in_acc, out_acc;

  assign s_axis_tready_o = (cnt_q <= 3'd1);
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == "_") || is_digit(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic word_t word_append(input word_t w, input logic [7:0] c,
                                        input logic [31:0] pos);
    word_t o;
    o = w;
    if (w.len == 8'd0) o.start = pos;
    if (w.len < TextCap) begin
      for (int k = 0; k < 4; k++) begin
        if ((w.len >= kw_len(2'(k))) || (kw_char(2'(k), w.len[2:0]) != c)) o.kf[k] = 1'b0;
      end
      if (w.nf[NumOk]) begin
        if (c == ".") begin
          if (w.nf[NumPoint]) o.nf[NumOk] = 1'b0;
          else o.nf[NumPoint] = 1'b1;
        end else if (is_digit(c)) begin
          if (w.nf[NumPoint]) o.nf[NumAfter] = 1'b1;
          else o.nf[NumBefore] = 1'b1;
        end else begin
          o.nf[NumOk] = 1'b0;
        end
      end
      o.len = w.len + 8'd1;
    end
    return o;
  endfunction

  function automatic logic [4:0] word_kind(input word_t w);
    logic [4:0] kind;
    logic       found;
    kind  = KIND_IDENT;
    found = 1'b0;
    // lowest matching keyword wins
    for (int k = 3; k >= 0; k--) begin
      if (w.kf[k] && (w.len == kw_len(2'(k)))) begin
        kind  = 5'(k);
        found = 1'b1;
      end
    end
    if (!found && w.nf[NumOk]) begin
      if (!w.nf[NumPoint]) kind = KIND_INT;
      else if (w.nf[NumBefore] || w.nf[NumAfter]) kind = KIND_FLOAT;
    end
    return kind;
  endfunction

  function automatic res_t mk_res(input logic [4:0] kind, input logic [31:0] line,
                                  input logic [31:0] start, input logic [7:0] len,
                                  input logic err);
    res_t r;
    r.kind  = kind;
    r.line  = line;
    r.start = start;
    r.len   = len;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

  // one pass over the accepted item, in the order of the scanning rules
  always_comb begin
    logic [7:0]  c;
    logic [31:0] pos;
    logic        do_scan;
    logic [3:0]  pc;
    logic [4:0]  sk;
    c        = s_axis_tdata_i;
    pos      = bpos_q;
    do_scan  = 1'b0;
    pc       = pend_code(c);
    sk       = single_kind(c);
    mode_d   = mode_q;
    pend_d   = pend_q;
    word_d   = word_q;
    qlen_d   = qlen_q;
    qstart_d = qstart_q;
    bpos_d   = bpos_q;
    lcnt_d   = lcnt_q;
    nres     = 2'd0;
    for (int i = 0; i < ResultSlots; i++) slot[i] = mk_res(KIND_NONE, 32'd0, 32'd0, 8'd0, 1'b0);

    if (mode_q == MODE_HALTED) begin
      // halted: nothing happens until reset
    end else if (s_axis_tlast_i) begin
      // end of input: flush text, pending operator and word, then end token
      if (mode_q == MODE_DQUOTE || mode_q == MODE_SQUOTE) begin
        slot[nres] = mk_res((mode_q == MODE_DQUOTE) ? KIND_TEXT : KIND_LETTER,
                            lcnt_d, qstart_q, qlen_q, 1'b0);
        nres   = nres + 2'd1;
        mode_d = MODE_NORMAL;
      end
      pend_d = PEND_NONE;
      if (pend_q == PEND_DOT) begin
        if (word_d.len != 8'd0) begin
          slot[nres] = mk_res(word_kind(word_d), lcnt_d, word_d.start, word_d.len, 1'b0);
          nres   = nres + 2'd1;
          word_d = WordReset;
        end
        slot[nres] = mk_res(KIND_DOT, lcnt_d, bpos_q - 32'd1, 8'd1, 1'b0);
        nres = nres + 2'd1;
      end else if (pend_q != PEND_NONE) begin
        slot[nres] = mk_res(pend_one(pend_q), lcnt_d, bpos_q - 32'd1, 8'd1, 1'b0);
        nres = nres + 2'd1;
      end
      if (word_d.len != 8'd0) begin
        slot[nres] = mk_res(word_kind(word_d), lcnt_d, word_d.start, word_d.len, 1'b0);
        nres   = nres + 2'd1;
        word_d = WordReset;
      end
      slot[nres] = mk_res(KIND_END, lcnt_d, bpos_q, 8'd0, 1'b0);
      nres = nres + 2'd1;
    end else if (mode_q == MODE_DQUOTE || mode_q == MODE_SQUOTE) begin
      bpos_d = bpos_q + 32'd1;
      if (c == ((mode_q == MODE_DQUOTE) ? 8'h22 : 8'h27)) begin
        slot[nres] = mk_res((mode_q == MODE_DQUOTE) ? KIND_TEXT : KIND_LETTER,
                            lcnt_d, qstart_q, qlen_q, 1'b0);
        nres   = nres + 2'd1;
        mode_d = MODE_NORMAL;
      end else if (qlen_q < TextCap) begin
        qlen_d = qlen_q + 8'd1;
      end
    end else begin
      bpos_d  = bpos_q + 32'd1;
      do_scan = 1'b1;
      pend_d  = PEND_NONE;
      // resolve the pending operator with this byte
      if (pend_q == PEND_DOT) begin
        if (is_digit(c)) begin
          word_d = word_append(word_d, ".", pos - 32'd1);
        end else begin
          if (word_d.len != 8'd0) begin
            slot[nres] = mk_res(word_kind(word_d), lcnt_d, word_d.start, word_d.len, 1'b0);
            nres   = nres + 2'd1;
            word_d = WordReset;
          end
          slot[nres] = mk_res(KIND_DOT, lcnt_d, pos - 32'd1, 8'd1, 1'b0);
          nres = nres + 2'd1;
        end
      end else if (pend_q != PEND_NONE) begin
        if (c == pend_second(pend_q)) begin
          slot[nres] = mk_res(pend_two(pend_q), lcnt_d, pos - 32'd1, 8'd2, 1'b0);
          nres    = nres + 2'd1;
          do_scan = 1'b0;
        end else begin
          slot[nres] = mk_res(pend_one(pend_q), lcnt_d, pos - 32'd1, 8'd1, 1'b0);
          nres = nres + 2'd1;
        end
      end
      // normal scan of this byte
      if (do_scan) begin
        if (c == 8'h0a) lcnt_d = lcnt_q + 32'd1;
        if (c == 8'h22 || c == 8'h27) begin
          // a quote leaves any open word as it is
          mode_d   = (c == 8'h22) ? MODE_DQUOTE : MODE_SQUOTE;
          qstart_d = pos + 32'd1;
          qlen_d   = 8'd0;
        end else if (is_space(c)) begin
          if (word_d.len != 8'd0) begin
            slot[nres] = mk_res(word_kind(word_d), lcnt_d, word_d.start, word_d.len, 1'b0);
            nres   = nres + 2'd1;
            word_d = WordReset;
          end
        end else if (is_wordch(c)) begin
          word_d = word_append(word_d, c, pos);
        end else if (c == ".") begin
          pend_d = PEND_DOT;
        end else if (pc != PEND_NONE || sk != KIND_NONE) begin
          if (word_d.len != 8'd0) begin
            slot[nres] = mk_res(word_kind(word_d), lcnt_d, word_d.start, word_d.len, 1'b0);
            nres   = nres + 2'd1;
            word_d = WordReset;
          end
          if (pc != PEND_NONE) begin
            pend_d = pc;
          end else begin
            slot[nres] = mk_res(sk, lcnt_d, pos, 8'd1, 1'b0);
            nres = nres + 2'd1;
          end
        end else begin
          // invalid byte
          slot[nres] = mk_res(KIND_NONE, lcnt_d, pos, 8'd0, 1'b1);
          nres   = nres + 2'd1;
          mode_d = MODE_HALTED;
        end
      end
    end
    // mark the final result of this item
    for (int i = 0; i < ResultSlots; i++) begin
      if (nres != 2'd0 && 2'(i) == nres - 2'd1) slot[i].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      pend_q   <= PEND_NONE;
      word_q   <= WordReset;
      qlen_q   <= 8'd0;
      qstart_q <= 32'd0;
      bpos_q   <= 32'd0;
      lcnt_q   <= 32'd0;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      word_q   <= word_d;
      qlen_q   <= qlen_d;
      qstart_q <= qstart_d;
      bpos_q   <= bpos_d;
      lcnt_q   <= lcnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < ResultSlots; i++) begin
        if (2'(i) < nres) queue_q[wr_q + 2'(i)] <= slot[i];
      end
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (in_acc) wr_q <= wr_q + nres;
      if (out_acc) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (in_acc ? {1'b0, nres} : 3'd0) - (out_acc ? 3'd1 : 3'd0);
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tdata_o  = {queue_q[rd_q].len, queue_q[rd_q].start, queue_q[rd_q].line};
  assign m_axis_tuser_o  = {queue_q[rd_q].err, queue_q[rd_q].kind};
  assign m_axis_tlast_o  = queue_q[rd_q].last;

endmodule

// ===== sv/ctscan_checker.sv =====
// port level checks for the c subset token scanner, bound to the top level
`timescale 1ns / 1ps
module ctscan_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [5:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // stalled token holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled token changed");

  // error token closes its run
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[5] |-> m_axis_tlast_o)
    else $error("error token without tlast");

  // error token carries kind zero and no text
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[5] |->
      m_axis_tuser_o[4:0] == 5'd0 && m_axis_tdata_o[71:64] == 8'd0)
    else $error("malformed error token");

  // end token closes its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == 6'd31 |-> m_axis_tlast_o)
    else $error("end token without tlast");

endmodule

bind c_subset_token_scanner ctscan_checker u_ctscan_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
